// File: sv/assert_macros.svh
// Assertion macros shared by the double-ended queue checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque assertion failed: next-cycle implication");

`endif

// File: sv/deq_pkg.sv
// Package for the double-ended queue: sizes, codes and word types.
// No dependencies; imported by every module of the block.
`default_nettype none
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OCC_W = 5;

    typedef enum logic [1:0] {
        ACT_PUSH_REAR  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } t_action;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [WORD_W-1:0]  push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_W-1:0]  popped_value;
        logic [1:0]                status;
        logic [OCC_W-1:0]          occupancy;
    } t_out_word;

    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic load;
    } t_cell_ctl;

endpackage
`default_nettype wire

// File: sv/deq_cell.sv
// One storage cell of the deque row: holds a word, shifts to either side or loads.
// Depends on deq_pkg.
`default_nettype none
module deq_cell
    import deq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic signed [WORD_W-1:0] i_push_word,
    input  wire logic signed [WORD_W-1:0] i_left_word,
    input  wire logic signed [WORD_W-1:0] i_right_word,
    output logic signed [WORD_W-1:0]      o_word
);

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.shift_right) begin
            n_word = i_left_word;
        end else if (i_ctl.shift_left) begin
            n_word = i_right_word;
        end else if (i_ctl.load) begin
            n_word = i_push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

// File: sv/double_ended_queue_unit.sv
// Double-ended queue of DEPTH signed 32-bit words held in a row of shift cells.
// A result word is presented in the cycle after its input word is accepted.
// Throughput: one input word per cycle while the result side keeps taking words.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// the stored words themselves are not cleared and need no clearing pass.
`default_nettype none
module double_ended_queue_unit
    import deq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out
);

    // The queue is kept front-aligned: cell 0 always holds the front word and
    // cell (count - 1) the rear word. A push at the front shifts the whole row
    // one place towards the rear, a pop from the front shifts it one place back,
    // a push at the rear loads the first free cell and a pop from the rear only
    // shrinks the count.

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_word        r_out;
    t_out_word        n_out;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_push_rear;
    logic                     w_push_front;
    logic                     w_pop_front;
    logic                     w_pop_rear;
    logic [IDX_W-1:0]         w_rear_idx;
    logic signed [WORD_W-1:0] w_words [DEPTH];

    // A new word may enter whenever the output register is free or is being
    // emptied in this very cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_push_rear  = 1'b0;
        w_push_front = 1'b0;
        w_pop_front  = 1'b0;
        w_pop_rear   = 1'b0;
        case (i_in.action)
            ACT_PUSH_REAR:  w_push_rear  = w_accept && !w_full;
            ACT_PUSH_FRONT: w_push_front = w_accept && !w_full;
            ACT_POP_FRONT:  w_pop_front  = w_accept && !w_empty;
            ACT_POP_REAR:   w_pop_rear   = w_accept && !w_empty;
            default: begin
            end
        endcase
    end

    // The rear word sits in the cell just below the count.
    assign w_rear_idx = IDX_W'(r_count - CNT_W'(1));

    // Row of cells. The first cell takes the pushed word when the row shifts
    // towards the rear; the last cell simply keeps its own word when the row
    // shifts towards the front, as that place becomes free.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl                w_ctl;
        logic signed [WORD_W-1:0] w_left;
        logic signed [WORD_W-1:0] w_right;

        assign w_ctl.shift_right = w_push_front;
        assign w_ctl.shift_left  = w_pop_front;
        assign w_ctl.load        = w_push_rear && (r_count == CNT_W'(g));

        if (g == 0) begin : g_first
            assign w_left = i_in.push_value;
        end else begin : g_inner_left
            assign w_left = w_words[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_words[g];
        end else begin : g_inner_right
            assign w_right = w_words[g+1];
        end

        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_push_word  (i_in.push_value),
            .i_left_word  (w_left),
            .i_right_word (w_right),
            .o_word       (w_words[g])
        );
    end

    // Next count and the result word for the accepted action.
    always_comb begin
        n_count = r_count;
        if (w_push_rear || w_push_front) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop_front || w_pop_rear) begin
            n_count = r_count - CNT_W'(1);
        end

        n_out.popped_value = '0;
        n_out.status       = ST_DONE;
        if (w_pop_front) begin
            n_out.popped_value = w_words[0];
        end else if (w_pop_rear) begin
            n_out.popped_value = w_words[w_rear_idx];
        end

        if ((i_in.action inside {ACT_PUSH_REAR, ACT_PUSH_FRONT}) && w_full) begin
            n_out.status = ST_FULL;
        end else if ((i_in.action inside {ACT_POP_FRONT, ACT_POP_REAR}) && w_empty) begin
            n_out.status = ST_EMPTY;
        end
        n_out.occupancy = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// File: sv/deq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on deq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module deq_checker
    import deq_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_word o_out
);

    // An accepted word always yields a result word in the following cycle.
    `DEQ_ASSERT_NXT(a_result_follows, i_clk, i_rst_n,
                    i_in_valid && o_in_ready, o_out_valid)

    // A result word waits, unchanged, until the consumer takes it.
    `DEQ_ASSERT_NXT(a_result_holds, i_clk, i_rst_n,
                    o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))

    // Failed actions return no data.
    `DEQ_ASSERT_IMP(a_error_no_data, i_clk, i_rst_n,
                    o_out_valid && o_out.status != ST_DONE, o_out.popped_value == '0)

    // While a result waits and is not taken, no new word may enter.
    `DEQ_ASSERT_IMP(a_stall_blocks, i_clk, i_rst_n,
                    o_out_valid && !i_out_ready, !o_in_ready)

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire
